// File: sv/alr_pkg.sv
// ----------------------------------------------------------------------------
// Antialiased line rasteriser package
// Shared widths, payload types and the sequencer state type.
// ----------------------------------------------------------------------------
package alr_pkg;

   localparam int COORD_INT_BITS     = 12;
   localparam int COORD_FRAC_BITS    = 8;
   localparam int GRADIENT_FRAC_BITS = 16;

   localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int MAJOR_W = COORD_INT_BITS + 1;
   localparam int MINOR_W = COORD_INT_BITS + GRADIENT_FRAC_BITS + 2;
   localparam int GRAD_W  = GRADIENT_FRAC_BITS + 2;
   localparam int QUOT_W  = GRADIENT_FRAC_BITS + 1;
   localparam int COV_W   = GRADIENT_FRAC_BITS + COORD_FRAC_BITS + 1;
   localparam int IP_W    = COORD_INT_BITS + 2;

   localparam logic ACTION_START   = 1'b0;
   localparam logic ACTION_ADVANCE = 1'b1;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [7:0]         color_red;
      logic [7:0]         color_green;
      logic [7:0]         color_blue;
      logic               top_edge;
      logic               bottom_edge;
   } alr_req_type;

   typedef struct packed {
      logic [MAJOR_W-1:0] pixel_x;
      logic [MAJOR_W-1:0] pixel_y;
      logic [7:0]         pixel_red;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_blue;
      logic               last;
   } alr_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_EP_MUL,
      ST_EP_Y,
      ST_PX_MUL,
      ST_PX_OUT
   } alr_state_type;

endpackage

// File: sv/alr_divider.sv
// ----------------------------------------------------------------------------
// Gradient divider
// Restoring divider, one quotient bit per cycle, rounding to nearest.
// ----------------------------------------------------------------------------
module alr_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [alr_pkg::COORD_W-1:0] numer_mag,
   input  logic [alr_pkg::COORD_W-1:0] divisor,
   output logic                        done,
   output logic [alr_pkg::QUOT_W-1:0]  quotient
);

   localparam int W   = alr_pkg::COORD_W;
   localparam int G   = alr_pkg::GRADIENT_FRAC_BITS;
   localparam int QW  = alr_pkg::QUOT_W;
   localparam int CNW = $clog2(QW + 1);

   logic [W+G:0]   full;
   logic [W-1:0]   rem_ff;
   logic [QW-1:0]  low_ff;
   logic [QW-1:0]  quot_ff;
   logic [W-1:0]   div_ff;
   logic [CNW-1:0] count_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [W:0]     trial;
   logic           fits;

   // Half the divisor is added up front so that truncation rounds half up.
   assign full  = {1'b0, numer_mag, {G{1'b0}}} + (W+G+1)'(divisor >> 1);
   assign trial = {rem_ff, low_ff[QW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNW'(QW);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= W'(full >> QW);
         low_ff  <= full[QW-1:0];
         div_ff  <= divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? W'(trial - {1'b0, div_ff}) : W'(trial);
         low_ff  <= {low_ff[QW-2:0], 1'b0};
         quot_ff <= {quot_ff[QW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: sv/antialiased_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Antialiased line rasteriser
// Wu-style line generator: endpoint pairs on start, interior pairs on advance.
// ----------------------------------------------------------------------------
// A start request is taken only while the block is idle. It passes through a
// setup state, then the bit-serial gradient divider (skipped when the major
// span is zero), then EP_MUL and EP_Y per endpoint and PX_MUL and PX_OUT per
// pixel before it is ready again; PX_OUT waits while the result side stalls.
// An advance request runs PX_MUL and PX_OUT for each pixel, paced by the
// single shared coverage multiplier and the one result register. Pixels leave
// in the order endpoint 0 lower, upper, endpoint 1 lower, upper; interior
// pairs give the lower minor pixel first, and last marks the final pixel.
module antialiased_line_rasterizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  alr_pkg::alr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output alr_pkg::alr_rsp_type rsp_data
);

   localparam int CI  = alr_pkg::COORD_INT_BITS;
   localparam int C   = alr_pkg::COORD_FRAC_BITS;
   localparam int G   = alr_pkg::GRADIENT_FRAC_BITS;
   localparam int W   = alr_pkg::COORD_W;
   localparam int MJW = alr_pkg::MAJOR_W;
   localparam int MW  = alr_pkg::MINOR_W;
   localparam int GW  = alr_pkg::GRAD_W;
   localparam int QW  = alr_pkg::QUOT_W;
   localparam int CVW = alr_pkg::COV_W;
   localparam int IPW = alr_pkg::IP_W;
   localparam int PW  = GW + C + 1;
   localparam int K   = G + C;
   localparam int UP  = (G >= C) ? G - C : 0;
   localparam int DN  = (C > G) ? C - G : 0;

   alr_pkg::alr_state_type state_ff, state_in;

   // line state
   logic                   active_ff;
   logic                   steep_ff;
   logic [MJW-1:0]         pos_ff;
   logic [MJW-1:0]         end_ff;
   logic signed [MW-1:0]   minor_ff;
   logic signed [GW-1:0]   grad_ff;
   logic [23:0]            color_ff;
   logic [1:0]             edges_ff;

   // setup working registers
   logic [W-1:0]           x0_ff, y0_ff, x1_ff, y1_ff;
   logic                   neg_ff;
   logic                   ep_sel_ff;
   logic                   half_ff;
   logic                   interior_ff;
   logic                   last_int_ff;
   logic                   end_now_ff;
   logic [MJW-1:0]         m_ff;
   logic [MJW-1:0]         m0_ff;
   logic [C:0]             xgap_ff;
   logic signed [PW-1:0]   prod_ff;
   logic [G-1:0]           fy_ff;
   logic signed [IPW-1:0]  ip_ff;
   logic signed [MW-1:0]   y0raw_ff;

   // pixel registers
   logic [MJW-1:0]         px_major_ff;
   logic signed [IPW:0]    px_minor_ff;
   logic [CVW-1:0]         px_cov_ff;
   logic                   px_last_ff;

   logic                   rsp_valid_ff;
   alr_pkg::alr_rsp_type   rsp_data_ff;

   // control
   logic                   accept;
   logic                   adv_ok;
   logic                   load_out;
   logic                   div_start;
   logic                   div_done;
   logic [QW-1:0]          quotient;

   // setup datapath
   logic [W-1:0]           ax, ay;
   logic                   steep;
   logic [W-1:0]           sx0, sy0, sx1, sy1;
   logic                   order_swap;
   logic [W-1:0]           ox0, oy0, ox1, oy1;
   logic [W-1:0]           dx;
   logic [W-1:0]           dy_mag;
   logic                   dy_neg;

   // endpoint datapath
   logic [W-1:0]           ex, ey;
   logic [W:0]             xh;
   logic [MJW-1:0]         m_cur;
   logic signed [W+1:0]    off_wide;
   logic signed [C:0]      off;
   logic [W+G-1:0]         tg_wide;
   logic [CI+G-1:0]        tg;
   logic signed [MW-1:0]   yraw;
   logic signed [MW-1:0]   yend;
   logic [MJW:0]           span;

   // pixel datapath
   logic [G:0]             fy_ext;
   logic [G:0]             gone_minus_fy;
   logic [G:0]             mul_a;
   logic [G+C+1:0]         mul_p;

   // interior step
   logic [MJW:0]           step_i;

   // emission
   logic [MJW-1:0]         minor_sat;
   logic [CVW+8:0]         shade_t;
   logic [7:0]             shade_add;
   logic [8:0]             sum_r, sum_g, sum_b;

   localparam logic [G:0] GONE = (G+1)'(1) << G;

   alr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer_mag (dy_mag),
      .divisor   (dx),
      .done      (div_done),
      .quotient  (quotient)
   );

   // ---------------- setup: axis swap and endpoint ordering ----------------
   always_comb begin
      ax         = (x1_ff > x0_ff) ? x1_ff - x0_ff : x0_ff - x1_ff;
      ay         = (y1_ff > y0_ff) ? y1_ff - y0_ff : y0_ff - y1_ff;
      steep      = ay > ax;
      sx0        = steep ? y0_ff : x0_ff;
      sy0        = steep ? x0_ff : y0_ff;
      sx1        = steep ? y1_ff : x1_ff;
      sy1        = steep ? x1_ff : y1_ff;
      order_swap = sx0 > sx1;
      ox0        = order_swap ? sx1 : sx0;
      oy0        = order_swap ? sy1 : sy0;
      ox1        = order_swap ? sx0 : sx1;
      oy1        = order_swap ? sy0 : sy1;
      dx         = ox1 - ox0;
      dy_neg     = oy0 > oy1;
      dy_mag     = dy_neg ? oy0 - oy1 : oy1 - oy0;
   end

   // ---------------- endpoint datapath ----------------
   always_comb begin
      ex       = ep_sel_ff ? x1_ff : x0_ff;
      ey       = ep_sel_ff ? y1_ff : y0_ff;
      xh       = {1'b0, ex} + (W+1)'(1 << (C - 1));
      m_cur    = xh[W:C];
      off_wide = $signed({1'b0, m_cur, {C{1'b0}}}) - $signed({2'b00, ex});
      off      = off_wide[C:0];
      tg_wide  = ((W+G)'(ey) << UP) >> DN;
      tg       = tg_wide[CI+G-1:0];
      yraw     = $signed(MW'(tg)) + MW'(prod_ff >>> C);
      yend     = yraw[MW-1] ? '0 : yraw;
      span     = {1'b0, m_ff} - {1'b0, m0_ff};
   end

   // ---------------- coverage multiplier ----------------
   always_comb begin
      fy_ext        = {1'b0, fy_ff};
      gone_minus_fy = GONE - fy_ext;
      if (interior_ff) begin
         if (half_ff) begin
            mul_a = edges_ff[0] ? gone_minus_fy : GONE;
         end else begin
            mul_a = edges_ff[1] ? fy_ext : GONE;
         end
      end else begin
         mul_a = half_ff ? gone_minus_fy : fy_ext;
      end
      mul_p = mul_a * xgap_ff;
   end

   assign step_i = {1'b0, pos_ff} + 1'b1;
   assign adv_ok = active_ff && (step_i < {1'b0, end_ff});

   // ---------------- shading and saturation ----------------
   always_comb begin
      if (px_minor_ff < 0) begin
         minor_sat = '0;
      end else if (px_minor_ff > $signed((IPW+1)'(1) << CI)) begin
         minor_sat = MJW'(1) << CI;
      end else begin
         minor_sat = px_minor_ff[MJW-1:0];
      end
      // 255 * coverage, rounded half up at the coverage scale
      shade_t   = ({9'b0, px_cov_ff} << 8) - {9'b0, px_cov_ff}
                  + ((CVW+9)'(1) << (K - 1));
      shade_add = shade_t[K+7:K];
      sum_r     = {1'b0, color_ff[23:16]} + {1'b0, shade_add};
      sum_g     = {1'b0, color_ff[15:8]}  + {1'b0, shade_add};
      sum_b     = {1'b0, color_ff[7:0]}   + {1'b0, shade_add};
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == alr_pkg::ACTION_START) begin
                  state_in = alr_pkg::ST_SETUP;
               end else if (adv_ok) begin
                  state_in = alr_pkg::ST_PX_MUL;
               end
            end
         end
         alr_pkg::ST_SETUP: begin
            state_in = (dx == '0) ? alr_pkg::ST_EP_MUL : alr_pkg::ST_DIV;
         end
         alr_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = alr_pkg::ST_EP_MUL;
            end
         end
         alr_pkg::ST_EP_MUL: state_in = alr_pkg::ST_EP_Y;
         alr_pkg::ST_EP_Y:   state_in = alr_pkg::ST_PX_MUL;
         alr_pkg::ST_PX_MUL: state_in = alr_pkg::ST_PX_OUT;
         alr_pkg::ST_PX_OUT: begin
            if (load_out) begin
               if (!half_ff) begin
                  state_in = alr_pkg::ST_PX_MUL;
               end else if (interior_ff || ep_sel_ff) begin
                  state_in = alr_pkg::ST_IDLE;
               end else begin
                  state_in = alr_pkg::ST_EP_MUL;
               end
            end
         end
         default: state_in = alr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         alr_pkg::ST_IDLE:   req_ready = 1'b1;
         alr_pkg::ST_SETUP:  div_start = (dx != '0);
         alr_pkg::ST_PX_OUT: load_out  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alr_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         steep_ff     <= 1'b0;
         pos_ff       <= '0;
         end_ff       <= '0;
         minor_ff     <= '0;
         grad_ff      <= '0;
         color_ff     <= '0;
         edges_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ep_sel_ff    <= 1'b0;
         half_ff      <= 1'b0;
         interior_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            alr_pkg::ST_IDLE: begin
               if (accept) begin
                  if (req_data.action == alr_pkg::ACTION_START) begin
                     color_ff    <= {req_data.color_red, req_data.color_green,
                                     req_data.color_blue};
                     edges_ff    <= {req_data.bottom_edge, req_data.top_edge};
                     interior_ff <= 1'b0;
                     ep_sel_ff   <= 1'b0;
                     half_ff     <= 1'b0;
                  end else if (adv_ok) begin
                     pos_ff      <= step_i[MJW-1:0];
                     minor_ff    <= minor_ff + MW'(grad_ff);
                     interior_ff <= 1'b1;
                     half_ff     <= 1'b0;
                     if (step_i + 1'b1 >= {1'b0, end_ff}) begin
                        active_ff <= 1'b0;
                     end
                  end else begin
                     active_ff <= 1'b0;
                  end
               end
            end
            alr_pkg::ST_SETUP: begin
               steep_ff <= steep;
               if (order_swap) begin
                  edges_ff <= {edges_ff[0], edges_ff[1]};
               end
               if (dx == '0) begin
                  grad_ff <= GW'(GONE);
               end
            end
            alr_pkg::ST_DIV: begin
               if (div_done) begin
                  grad_ff <= neg_ff ? -$signed(GW'(quotient)) : $signed(GW'(quotient));
               end
            end
            alr_pkg::ST_EP_Y: begin
               if (ep_sel_ff) begin
                  pos_ff    <= m0_ff;
                  end_ff    <= m_ff;
                  minor_ff  <= y0raw_ff + MW'(grad_ff);
                  active_ff <= span > (MJW+1)'(1);
               end
            end
            alr_pkg::ST_PX_OUT: begin
               if (load_out) begin
                  if (!half_ff) begin
                     half_ff <= 1'b1;
                  end else if (!interior_ff && !ep_sel_ff) begin
                     ep_sel_ff <= 1'b1;
                     half_ff   <= 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         alr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.action == alr_pkg::ACTION_START) begin
                  x0_ff <= req_data.start_x;
                  y0_ff <= req_data.start_y;
                  x1_ff <= req_data.end_x;
                  y1_ff <= req_data.end_y;
               end else begin
                  fy_ff       <= minor_ff[G-1:0];
                  ip_ff       <= minor_ff[MW-1:G];
                  xgap_ff     <= (C+1)'(1) << C;
                  last_int_ff <= step_i + 1'b1 >= {1'b0, end_ff};
                  px_major_ff <= step_i[MJW-1:0];
               end
            end
         end
         alr_pkg::ST_SETUP: begin
            x0_ff  <= ox0;
            y0_ff  <= oy0;
            x1_ff  <= ox1;
            y1_ff  <= oy1;
            neg_ff <= dy_neg;
         end
         alr_pkg::ST_EP_MUL: begin
            m_ff    <= m_cur;
            xgap_ff <= ((C+1)'(1) << C) - {1'b0, xh[C-1:0]};
            prod_ff <= PW'(grad_ff * off);
         end
         alr_pkg::ST_EP_Y: begin
            fy_ff       <= yend[G-1:0];
            ip_ff       <= yend[MW-1:G];
            px_major_ff <= m_ff;
            if (!ep_sel_ff) begin
               m0_ff    <= m_ff;
               y0raw_ff <= yraw;
            end else begin
               end_now_ff <= span <= (MJW+1)'(1);
            end
         end
         alr_pkg::ST_PX_MUL: begin
            px_cov_ff   <= mul_p[CVW-1:0];
            px_minor_ff <= (IPW+1)'(ip_ff) + (IPW+1)'(half_ff);
            px_last_ff  <= half_ff && (interior_ff ? last_int_ff
                                                   : (ep_sel_ff && end_now_ff));
         end
         alr_pkg::ST_PX_OUT: begin
            if (load_out) begin
               rsp_data_ff.pixel_x     <= steep_ff ? minor_sat : px_major_ff;
               rsp_data_ff.pixel_y     <= steep_ff ? px_major_ff : minor_sat;
               rsp_data_ff.pixel_red   <= sum_r[8] ? 8'hFF : sum_r[7:0];
               rsp_data_ff.pixel_green <= sum_g[8] ? 8'hFF : sum_g[7:0];
               rsp_data_ff.pixel_blue  <= sum_b[8] ? 8'hFF : sum_b[7:0];
               rsp_data_ff.last        <= px_last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Antialiased line rasteriser testbench
// Drives start and advance requests through a short directed table and then
// random line sequences, with random idling on both channels. Every pixel is
// checked field by field against an in-order queue filled by a line tracer that
// mirrors the block's fixed-point arithmetic, or by typed pixels for some rows.
// ----------------------------------------------------------------------------
module testbench;
   import alr_pkg::*;

   localparam int  MAX_CYCLES = 400000;
   localparam int  RANDOM_REQUESTS = 280;
   localparam longint GRAD_ONE = longint'(1) << GRADIENT_FRAC_BITS;
   localparam longint HALF_PX  = longint'(1) << (COORD_FRAC_BITS - 1);
   localparam longint PX_MASK  = (longint'(1) << COORD_FRAC_BITS) - 1;
   localparam longint COORD_MAX = (longint'(1) << COORD_W) - 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   alr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   alr_rsp_type rsp_data;

   antialiased_line_rasterizer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Tracer state
   bit          line_on;
   bit          line_steep;
   longint      major_pos;
   longint      major_stop;
   longint      minor_pos;
   longint      gradient;
   logic [23:0] line_colour;
   logic [1:0]  line_edges;
   alr_rsp_type traced[4];

   alr_rsp_type pixel_q[$];
   alr_rsp_type typed_px[4];
   int          typed_n = -1;
   int          taken = 0;
   int          mismatches = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;

   function automatic logic [7:0] lighten(logic [7:0] c, longint num, int k);
      longint v;
      v = longint'(c) + ((255 * num + (longint'(1) << (k - 1))) >>> k);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [MAJOR_W-1:0] clip_coord(longint v);
      longint lim;
      lim = longint'(1) << COORD_INT_BITS;
      if (v < 0) return '0;
      if (v > lim) return lim[MAJOR_W-1:0];
      return v[MAJOR_W-1:0];
   endfunction

   function automatic alr_rsp_type make_pixel(longint major, longint minor, longint num,
                                              int k, bit fin);
      alr_rsp_type p;
      p.pixel_x     = clip_coord(line_steep ? minor : major);
      p.pixel_y     = clip_coord(line_steep ? major : minor);
      p.pixel_red   = lighten(line_colour[23:16], num, k);
      p.pixel_green = lighten(line_colour[15:8], num, k);
      p.pixel_blue  = lighten(line_colour[7:0], num, k);
      p.last        = fin;
      return p;
   endfunction

   // Returns the minor position at the endpoint's major pixel before clamping.
   function automatic longint trace_endpoint(longint x, longint y, int slot, bit fin,
                                             output longint m);
      longint off, yraw, yend, xgap, fy, ip;
      int     k;
      k    = GRADIENT_FRAC_BITS + COORD_FRAC_BITS;
      m    = (x + HALF_PX) >>> COORD_FRAC_BITS;
      off  = (m <<< COORD_FRAC_BITS) - x;
      yraw = (y <<< (GRADIENT_FRAC_BITS - COORD_FRAC_BITS))
             + ((gradient * off) >>> COORD_FRAC_BITS);
      yend = (yraw < 0) ? 0 : yraw;
      xgap = (PX_MASK + 1) - ((x + HALF_PX) & PX_MASK);
      fy   = yend & (GRAD_ONE - 1);
      ip   = yend >>> GRADIENT_FRAC_BITS;
      traced[slot]     = make_pixel(m, ip, fy * xgap, k, 1'b0);
      traced[slot + 1] = make_pixel(m, ip + 1, (GRAD_ONE - fy) * xgap, k, fin);
      return yraw;
   endfunction

   function automatic int trace_line(alr_req_type r);
      longint x0, y0, x1, y1, ax, ay, t, dx, dy, mag, y0raw, m0, m1, fy, ip, nx;
      bit     top, bot, e, end_now, fin;
      if (r.action == ACTION_START) begin
         x0 = r.start_x; y0 = r.start_y; x1 = r.end_x; y1 = r.end_y;
         top = r.top_edge; bot = r.bottom_edge;
         ax = (x1 > x0) ? x1 - x0 : x0 - x1;
         ay = (y1 > y0) ? y1 - y0 : y0 - y1;
         line_steep = ay > ax;
         if (line_steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
         end
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
            e = top; top = bot; bot = e;
         end
         line_colour = {r.color_red, r.color_green, r.color_blue};
         line_edges  = {bot, top};
         dx = x1 - x0;
         dy = y1 - y0;
         if (dx == 0) begin
            gradient = GRAD_ONE;
         end else begin
            mag = (dy < 0) ? -dy : dy;
            mag = ((mag <<< GRADIENT_FRAC_BITS) + dx / 2) / dx;
            gradient = (dy < 0) ? -mag : mag;
         end
         y0raw   = trace_endpoint(x0, y0, 0, 1'b0, m0);
         m1      = (x1 + HALF_PX) >>> COORD_FRAC_BITS;
         end_now = (m1 - m0) <= 1;
         void'(trace_endpoint(x1, y1, 2, end_now, m1));
         major_pos  = m0;
         major_stop = m1;
         minor_pos  = y0raw + gradient;
         line_on    = !end_now;
         return 4;
      end
      if (!line_on || major_pos + 1 >= major_stop) begin
         line_on = 1'b0;
         return 0;
      end
      nx  = major_pos + 1;
      fy  = minor_pos & (GRAD_ONE - 1);
      ip  = minor_pos >>> GRADIENT_FRAC_BITS;
      fin = nx + 1 >= major_stop;
      traced[0] = make_pixel(nx, ip, line_edges[1] ? fy : GRAD_ONE,
                             GRADIENT_FRAC_BITS, 1'b0);
      traced[1] = make_pixel(nx, ip + 1, line_edges[0] ? GRAD_ONE - fy : GRAD_ONE,
                             GRADIENT_FRAC_BITS, fin);
      major_pos = nx;
      minor_pos += gradient;
      if (fin) line_on = 1'b0;
      return 2;
   endfunction

   // Acceptance and checking, sampled at the rising edge.
   always @(posedge clock) begin
      int          n;
      alr_rsp_type want;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            n = trace_line(req_data);
            if (typed_n >= 0) begin
               for (int i = 0; i < typed_n; i++) pixel_q.push_back(typed_px[i]);
            end else begin
               for (int i = 0; i < n; i++) pixel_q.push_back(traced[i]);
            end
            taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pixel %p", rsp_data);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pixel mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
   end

   always @(negedge clock) rsp_ready <= quiet || ($urandom_range(99) >= 32);

   task automatic send(alr_req_type r);
      int target;
      while (!quiet && $urandom_range(99) < 32) @(negedge clock);
      req_data  = r;
      req_valid = 1'b1;
      target    = taken + 1;
      do @(negedge clock); while (taken < target);
      req_valid = 1'b0;
      typed_n   = -1;
   endtask

   function automatic alr_req_type mk(bit act, longint sx, longint sy, longint ex,
                                      longint ey, longint r, longint g,
                                      longint b, longint tp, longint bt);
      alr_req_type q;
      q.action = act;
      q.start_x = sx[COORD_W-1:0]; q.start_y = sy[COORD_W-1:0];
      q.end_x = ex[COORD_W-1:0];   q.end_y = ey[COORD_W-1:0];
      q.color_red = r[7:0]; q.color_green = g[7:0]; q.color_blue = b[7:0];
      q.top_edge = tp[0]; q.bottom_edge = bt[0];
      return q;
   endfunction

   function automatic longint clip_in(longint v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   typedef struct {
      alr_req_type rq;
      int          n_typed;
      alr_rsp_type px[4];
   } row_type;

   initial begin
      row_type     rows[$];
      row_type     row;
      alr_req_type adv;
      int          count, kind, steps, span;
      longint      bx, by, ex, ey;

      adv = mk(ACTION_ADVANCE, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0);
      // Advance straight after reset gives nothing.
      row.rq = adv; row.n_typed = 0; rows.push_back(row);
      // Zero-length line at the origin: gradient is one and both ends coincide.
      row.rq = mk(ACTION_START, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 0);
      row.n_typed = 4;
      row.px[0] = '{13'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0};
      row.px[1] = '{13'd0, 13'd1, 8'd128, 8'd128, 8'd128, 1'b0};
      row.px[2] = '{13'd0, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0};
      row.px[3] = '{13'd0, 13'd1, 8'd128, 8'd128, 8'd128, 1'b1};
      rows.push_back(row);
      row.rq = adv; row.n_typed = 0; rows.push_back(row);
      row.n_typed = -1;
      // Shallow line, saturating colour, both edges shaded.
      row.rq = mk(ACTION_START, 16'h0040, 16'h0120, 16'h0a80, 16'h0390, 8'hff, 8'hf0, 8'h80, 1, 1);
      rows.push_back(row);
      repeat (4) begin row.rq = adv; rows.push_back(row); end
      // Steep line given in reverse order, so the edge flags swap.
      row.rq = mk(ACTION_START, 16'h0300, 16'h0a55, 16'h0155, 16'h0210, 8'h12, 8'h34, 8'h56, 1, 0);
      rows.push_back(row);
      repeat (3) begin row.rq = adv; rows.push_back(row); end
      // Near the top of the coordinate range, so pixel positions saturate.
      row.rq = mk(ACTION_START, COORD_MAX, COORD_MAX, COORD_MAX - 600, COORD_MAX - 300,
                  8'hff, 8'hff, 8'hff, 1, 1);
      rows.push_back(row);
      repeat (2) begin row.rq = adv; rows.push_back(row); end
      // Long diagonal, dropped part way by the next start.
      row.rq = mk(ACTION_START, 0, 0, COORD_MAX, COORD_MAX, 8'h01, 8'h02, 8'h03, 0, 1);
      rows.push_back(row);
      row.rq = adv; rows.push_back(row);
      // Falling line from the bottom edge, given from right to left.
      row.rq = mk(ACTION_START, 16'h01c0, 16'h0000, 16'h0800, 16'h0000 + 0, 8'h00, 8'h80, 8'hff, 0, 1);
      row.rq.end_y = '0;
      row.rq.start_y = 20'h00010;
      row.rq.start_x = 20'h00800;
      row.rq.end_x = 20'h001c0;
      rows.push_back(row);
      repeat (3) begin row.rq = adv; rows.push_back(row); end
      // Vertical line.
      row.rq = mk(ACTION_START, 16'h0500, 16'h0100, 16'h0500, 16'h0480, 8'h40, 8'h00, 8'hc0, 1, 0);
      rows.push_back(row);
      repeat (2) begin row.rq = adv; rows.push_back(row); end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         typed_n = rows[i].n_typed;
         for (int j = 0; j < 4; j++) typed_px[j] = rows[i].px[j];
         send(rows[i].rq);
      end

      count = 0;
      while (count < RANDOM_REQUESTS) begin
         quiet = (count >= 120 && count < 170);
         kind  = $urandom_range(99);
         bx = $urandom_range(20'hfffff, 0);
         by = $urandom_range(20'hfffff, 0);
         if (kind < 8) begin
            // Unstructured noise: any start or a stray advance.
            if ($urandom_range(1))
               send(mk(ACTION_START, bx, by, $urandom_range(20'hfffff, 0),
                       $urandom_range(20'hfffff, 0), $urandom, $urandom, $urandom,
                       $urandom_range(1), $urandom_range(1)));
            else
               send(mk(ACTION_ADVANCE, bx, by, bx, by, $urandom, $urandom, $urandom,
                       $urandom_range(1), $urandom_range(1)));
            count++;
         end else begin
            if (kind < 15) begin
               bx = $urandom_range(1, 0) ? $urandom_range(1500, 0) : COORD_MAX - $urandom_range(1500, 0);
               by = $urandom_range(1, 0) ? $urandom_range(1500, 0) : COORD_MAX - $urandom_range(1500, 0);
            end
            ex = clip_in(bx + $urandom_range(5000, 0) - 2500);
            ey = clip_in(by + $urandom_range(5000, 0) - 2500);
            span = int'((((ex > bx) ? ex - bx : bx - ex)
                          + ((ey > by) ? ey - by : by - ey)) / 256 + 2);
            // Some sequences are cut short by the next start.
            steps = (kind < 25) ? $urandom_range(span / 2, 0) : $urandom_range(span + 1, 0);
            send(mk(ACTION_START, bx, by, ex, ey, $urandom, $urandom, $urandom,
                    $urandom_range(1), $urandom_range(1)));
            count++;
            repeat (steps) begin
               send(mk(ACTION_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom_range(1), $urandom_range(1)));
               count++;
            end
         end
      end
      quiet = 1'b0;

      while (pixel_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
